FILE: src/button_debounce_hold_repeat_macros.svh
// ----------------------------------------------------------------------------
// Button debounce assertion macros
// Shared concurrent assertion forms for the button debouncer.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_HOLD_REPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_REPEAT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BDHR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BDHR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/bdhr_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce package
// Widths, button positions, register indexes and reset values.
// ----------------------------------------------------------------------------
package bdhr_pkg;

   localparam int TIME_BITS = 32;
   localparam int NOW_BITS  = 32;
   localparam int NUM_BTN   = 5;
   localparam int CSR_BITS  = 16;
   localparam int IDX_BITS  = 3;

   localparam int KEY_UP    = 0;
   localparam int KEY_LAMP  = 1;
   localparam int KEY_POWER = 2;
   localparam int KEY_MENU  = 3;
   localparam int KEY_DN    = 4;

   typedef logic [NUM_BTN-1:0]   btn_mask_type;
   typedef logic [TIME_BITS-1:0] time_type;

   // Buttons that step (up and down); the others give short events.
   localparam btn_mask_type STEP_BTNS = btn_mask_type'((1 << KEY_UP) | (1 << KEY_DN));

   typedef enum logic [IDX_BITS-1:0] {
      CSR_MENU_HOLD    = 3'd0,
      CSR_POWER_HOLD   = 3'd1,
      CSR_DEBOUNCE     = 3'd2,
      CSR_REPEAT_START = 3'd3,
      CSR_REPEAT_INTV  = 3'd4
   } csr_index_type;

   localparam logic [15:0] MENU_HOLD_RESET    = 16'd2000;
   localparam logic [15:0] POWER_HOLD_RESET   = 16'd2000;
   localparam logic [7:0]  DEBOUNCE_RESET     = 8'd40;
   localparam logic [15:0] REPEAT_START_RESET = 16'd600;
   localparam logic [15:0] REPEAT_INTV_RESET  = 16'd150;

endpackage

FILE: src/bdhr_if.sv
// ----------------------------------------------------------------------------
// Button debounce channel interfaces
// Valid/ready channels for update beats and result beats.
// ----------------------------------------------------------------------------
interface bdhr_req_if;
   import bdhr_pkg::*;
   logic                valid;
   logic                ready;
   logic [NOW_BITS-1:0] now_time;
   btn_mask_type        raw_mask;

   modport source (output valid, now_time, raw_mask, input ready);
   modport sink   (input valid, now_time, raw_mask, output ready);
endinterface

interface bdhr_rsp_if;
   import bdhr_pkg::*;
   logic         valid;
   logic         ready;
   btn_mask_type pressed_mask;
   btn_mask_type short_mask;
   btn_mask_type long_mask;
   btn_mask_type step_mask;

   modport source (output valid, pressed_mask, short_mask, long_mask, step_mask,
                   input ready);
   modport sink   (input valid, pressed_mask, short_mask, long_mask, step_mask,
                   output ready);
endinterface

FILE: src/button_debounce_hold_repeat.sv
// ----------------------------------------------------------------------------
// Button debouncer with long press and auto-repeat
// Five-button debounce, short/long press events and up/down repeat steps.
// ----------------------------------------------------------------------------
//   Channel  Direction  Content
//   req      in         now_time (32b ms), raw_mask (5b raw pressed bits)
//   rsp      out        pressed_mask, short_mask, long_mask, step_mask (5b each)
//   csr      in         write enable, 3b register index, 16b write data
//
// An update beat is held in the input register while the per-button logic
// works on it, then moves into the result register, from which it leaves on rsp.
// A new beat can be accepted every cycle while rsp does not stall; the per-button
// state updates in the same cycle the beat moves into the result register, so
// the next beat sees it.
// A stall on rsp holds the result register and, through it, the input register.
// Synchronous reset clears all button state and restores register defaults.
// ----------------------------------------------------------------------------
`include "button_debounce_hold_repeat_macros.svh"

module button_debounce_hold_repeat (
   input  logic                             clock,
   input  logic                             reset,
   bdhr_req_if.sink                         req,
   bdhr_rsp_if.source                       rsp,
   input  logic                             csr_write_en,
   input  logic [bdhr_pkg::IDX_BITS-1:0]    csr_index,
   input  logic [bdhr_pkg::CSR_BITS-1:0]    csr_wdata
);
   import bdhr_pkg::*;

   // Configuration registers.
   logic [15:0] menu_hold_ff;
   logic [15:0] power_hold_ff;
   logic [7:0]  debounce_ff;
   logic [15:0] repeat_start_ff;
   logic [15:0] repeat_intv_ff;

   // Input register stage.
   logic          s1_valid_ff;
   time_type      s1_now_ff;
   btn_mask_type  s1_raw_ff;

   // Per-button state.
   btn_mask_type  raw_latched_ff, raw_latched_in;
   btn_mask_type  stable_ff, stable_in;
   btn_mask_type  long_done_ff, long_done_in;
   time_type      raw_change_ff  [NUM_BTN];
   time_type      raw_change_in  [NUM_BTN];
   time_type      press_start_ff [NUM_BTN];
   time_type      press_start_in [NUM_BTN];
   time_type      last_step_ff   [NUM_BTN];
   time_type      last_step_in   [NUM_BTN];

   // Result register.
   logic          rsp_valid_ff;
   btn_mask_type  pressed_ff, short_ff, long_ff, step_ff;

   // Per-button working values.
   time_type      rc_el [NUM_BTN];
   time_type      ps_el [NUM_BTN];
   time_type      ls_el [NUM_BTN];
   time_type      ps_el_new [NUM_BTN];
   time_type      ls_el_new [NUM_BTN];
   time_type      hold_sel [NUM_BTN];
   btn_mask_type  chg, deb_ok, toggle, press, release_ev, long_mid, rep;
   btn_mask_type  short_m, long_m, step_m;
   logic          fire;

   // The input stage moves forward when the result register is empty or drains.
   assign fire      = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || fire;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         menu_hold_ff    <= MENU_HOLD_RESET;
         power_hold_ff   <= POWER_HOLD_RESET;
         debounce_ff     <= DEBOUNCE_RESET;
         repeat_start_ff <= REPEAT_START_RESET;
         repeat_intv_ff  <= REPEAT_INTV_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MENU_HOLD:    menu_hold_ff    <= csr_wdata;
            CSR_POWER_HOLD:   power_hold_ff   <= csr_wdata;
            CSR_DEBOUNCE:     debounce_ff     <= csr_wdata[7:0];
            CSR_REPEAT_START: repeat_start_ff <= csr_wdata;
            CSR_REPEAT_INTV:  repeat_intv_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input register. The time is cast to the counter width here.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_now_ff <= TIME_BITS'(req.now_time);
         s1_raw_ff <= req.raw_mask;
      end
   end

   // Per-button update. Each button is independent; the elapsed times against
   // the stored stamps are formed in parallel, and a stamp that this beat
   // rewrites to the current time is known to give an elapsed time of zero.
   always_comb begin
      raw_latched_in = s1_raw_ff;
      short_m        = '0;
      long_m         = '0;
      step_m         = '0;
      for (int i = 0; i < NUM_BTN; i++) begin
         rc_el[i] = s1_now_ff - raw_change_ff[i];
         ps_el[i] = s1_now_ff - press_start_ff[i];
         ls_el[i] = s1_now_ff - last_step_ff[i];

         if (i == KEY_MENU) begin
            hold_sel[i] = TIME_BITS'(menu_hold_ff);
         end else if (i == KEY_POWER) begin
            hold_sel[i] = TIME_BITS'(power_hold_ff);
         end else begin
            hold_sel[i] = '0;
         end

         // A fresh raw change has zero elapsed time, so it only passes
         // straight through when the debounce time is zero.
         chg[i]    = s1_raw_ff[i] ^ raw_latched_ff[i];
         deb_ok[i] = chg[i] ? (debounce_ff == 8'd0)
                            : (rc_el[i] >= TIME_BITS'(debounce_ff));
         toggle[i]     = deb_ok[i] && (stable_ff[i] ^ s1_raw_ff[i]);
         press[i]      = toggle[i] && s1_raw_ff[i];
         release_ev[i] = toggle[i] && !s1_raw_ff[i];
         stable_in[i]  = stable_ff[i] ^ toggle[i];
         long_mid[i]   = press[i] ? 1'b0 : long_done_ff[i];

         short_m[i] = release_ev[i] && !long_done_ff[i] && !STEP_BTNS[i];

         ps_el_new[i] = press[i] ? '0 : ps_el[i];
         ls_el_new[i] = press[i] ? '0 : ls_el[i];

         long_m[i] = (hold_sel[i] != '0) && stable_in[i] && !long_mid[i]
                     && (ps_el_new[i] >= hold_sel[i]);
         long_done_in[i] = long_mid[i] | long_m[i];

         rep[i] = STEP_BTNS[i] && stable_in[i]
                  && (ps_el_new[i] >= TIME_BITS'(repeat_start_ff))
                  && (ls_el_new[i] >= TIME_BITS'(repeat_intv_ff));
         step_m[i] = (press[i] && STEP_BTNS[i]) || rep[i];

         raw_change_in[i]  = chg[i] ? s1_now_ff : raw_change_ff[i];
         press_start_in[i] = press[i] ? s1_now_ff : press_start_ff[i];
         last_step_in[i]   = (press[i] || rep[i]) ? s1_now_ff : last_step_ff[i];
      end
   end

   // State commits only when the beat moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_latched_ff <= '0;
         stable_ff      <= '0;
         long_done_ff   <= '0;
         for (int i = 0; i < NUM_BTN; i++) begin
            raw_change_ff[i]  <= '0;
            press_start_ff[i] <= '0;
            last_step_ff[i]   <= '0;
         end
      end else if (fire) begin
         raw_latched_ff <= raw_latched_in;
         stable_ff      <= stable_in;
         long_done_ff   <= long_done_in;
         for (int i = 0; i < NUM_BTN; i++) begin
            raw_change_ff[i]  <= raw_change_in[i];
            press_start_ff[i] <= press_start_in[i];
            last_step_ff[i]   <= last_step_in[i];
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pressed_ff <= stable_in;
         short_ff   <= short_m;
         long_ff    <= long_m;
         step_ff    <= step_m;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pressed_mask = pressed_ff;
   assign rsp.short_mask   = short_ff;
   assign rsp.long_mask    = long_ff;
   assign rsp.step_mask    = step_ff;

   // A short event is only reported on a release.
   `BDHR_ASSERT_NOW(a_short_released, clock, reset, rsp_valid_ff,
                    (short_ff & pressed_ff) == '0, "short event on a pressed button")

   // A long event is only reported while the button is held.
   `BDHR_ASSERT_NOW(a_long_held, clock, reset, rsp_valid_ff,
                    (long_ff & ~pressed_ff) == '0, "long event on a released button")

   // Once reported, a long event is remembered for the rest of the press.
   `BDHR_ASSERT_NEXT(a_long_recorded, clock, reset, fire && (long_m != '0),
                     (long_done_ff & $past(long_m)) == $past(long_m),
                     "long event not recorded")

   // The debounced state only moves when a beat is processed.
   `BDHR_ASSERT_NEXT(a_stable_hold, clock, reset, !fire, $stable(stable_ff),
                     "stable state changed without a beat")

endmodule
